@@ sv/lruc_pkg.sv @@
package lruc_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic cmp_en;
    logic shift;
  } cell_ctl_t;

endpackage

@@ sv/lruc_cell.sv @@
module lruc_cell import lruc_pkg::*; (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic signed [KEY_W-1:0] cmp_key,
  input  entry_t                  prev,
  output entry_t                  entry,
  output logic                    match
);

  // one recency position: loads its younger neighbour on shift
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry <= prev;
    end
    if (ctl.cmp_en) begin
      match <= ctl.valid && (entry.key == cmp_key);
    end
  end

endmodule

@@ sv/lru_key_value_cache.sv @@
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    op, key, value
// out      output     out_valid / out_ready  hit, read_value, evicted, evicted_key
// cfg      input      cfg_valid / cfg_ready  cfg_data (capacity)
//
// The accept cycle compares the key in every cell; the update state then shifts
// the cell chain and loads the output register.
// Cells are kept in recency order, position 0 most recent; valid = position < fill.
// Reset clears the fill count and sets capacity to 16; no clearing pass.
// The update cycle waits while the output register holds an untaken result.
module lru_key_value_cache import lruc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic signed [KEY_W-1:0]  key,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     hit,
  output logic signed [DATA_W-1:0] read_value,
  output logic                     evicted,
  output logic signed [KEY_W-1:0]  evicted_key,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CAP_W-1:0]         cfg_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int CW = (FW > CAP_W) ? FW : CAP_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic                     state;
  logic [CAP_W-1:0]         capacity;
  logic [FW-1:0]            fill;
  logic [FW-1:0]            fill_next;
  logic                     op_hold;
  logic signed [KEY_W-1:0]  key_hold;
  logic signed [DATA_W-1:0] value_hold;

  entry_t    entries [ENTRIES];
  entry_t    prevs   [ENTRIES];
  cell_ctl_t ctls    [ENTRIES];
  logic [ENTRIES-1:0] match;

  logic                     accept;
  logic                     update_go;
  logic                     hit_any;
  logic [IW-1:0]            hidx;
  logic signed [DATA_W-1:0] hit_data;
  logic [CW-1:0]            cap_ext;
  logic [CW-1:0]            cap_min1;
  logic [CW-1:0]            cap_eff;
  logic                     evict_cond;
  logic                     do_evict;
  logic [FW:0]              put_lim;
  logic [IW-1:0]            last_idx;
  entry_t                   front;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign update_go = (state == ST_UPD) && (!out_valid || out_ready);

  always_comb begin
    hit_any  = |match;
    hidx     = '0;
    hit_data = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hidx     = hidx | IW'(i);
        hit_data = hit_data | entries[i].data;
      end
    end
  end

  always_comb begin
    cap_ext    = CW'(capacity);
    cap_min1   = (cap_ext == '0) ? CW'(1) : cap_ext;
    cap_eff    = (cap_min1 > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_min1;
    evict_cond = CW'(fill) >= cap_eff;
    do_evict   = (op_hold == OP_PUT) && !hit_any && evict_cond;
    put_lim    = evict_cond ? {1'b0, fill} : ({1'b0, fill} + (FW+1)'(1));
    last_idx   = IW'(fill - FW'(1));
    front.key  = key_hold;
    front.data = (op_hold == OP_PUT) ? value_hold : hit_data;
  end

  always_comb begin
    fill_next = fill;
    if ((op_hold == OP_PUT) && !hit_any && !evict_cond) begin
      fill_next = fill + FW'(1);
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prevs[g] = front;
    end else begin : g_body
      assign prevs[g] = entries[g-1];
    end

    always_comb begin
      ctls[g].valid  = FW'(g) < fill;
      ctls[g].cmp_en = accept;
      if (!update_go) begin
        ctls[g].shift = 1'b0;
      end else if (hit_any) begin
        ctls[g].shift = IW'(g) <= hidx;
      end else if (op_hold == OP_PUT) begin
        ctls[g].shift = (FW+1)'(g) < put_lim;
      end else begin
        ctls[g].shift = 1'b0;
      end
    end

    lruc_cell u_cell (
      .clk     (clk),
      .ctl     (ctls[g]),
      .cmp_key (key),
      .prev    (prevs[g]),
      .entry   (entries[g]),
      .match   (match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      capacity  <= CAP_W'(16);
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        state <= ST_UPD;
      end
      if (update_go) begin
        state     <= ST_IDLE;
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_hold    <= op;
      key_hold   <= key;
      value_hold <= value;
    end
    if (update_go) begin
      hit         <= hit_any;
      read_value  <= (op_hold == OP_PUT) ? '0 : (hit_any ? hit_data : MISS_VALUE);
      evicted     <= do_evict;
      evicted_key <= do_evict ? entries[last_idx].key : '0;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(ENTRIES))
    else $error("fill count beyond entries");

  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> $onehot0(match))
    else $error("key present in more than one cell");

  a_accept_update: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_UPD))
    else $error("accepted transaction not in update");

  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> (!hit && (read_value == '0)))
    else $error("eviction reported on a hit or a get");

endmodule
